/* design/index_linked_ring_pool_core_defines.svh */
// Assertion macros for the checker file of the ring pool core.
`ifndef INDEX_LINKED_RING_POOL_CORE_DEFINES_SVH
`define INDEX_LINKED_RING_POOL_CORE_DEFINES_SVH

// Next-cycle implication, masked while reset is high.
`define ILRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ring pool check failed");

// Next-cycle implication that also holds across reset.
`define ILRP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("ring pool check failed");

`endif

/* design/ilrp_pkg.sv */
// Package with constants, codes and controller/datapath types of the ring pool.
package ilrp_pkg;

   localparam int ENTRIES = 256;
   localparam int LINK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int IDX_W   = 8;

   localparam logic [1:0] OP_MOVE  = 2'd0;
   localparam logic [1:0] OP_CROSS = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // Datapath step selects which link writes and captures happen this cycle.
   localparam logic [2:0] STEP_IDLE = 3'd0;
   localparam logic [2:0] STEP_CLR  = 3'd1;
   localparam logic [2:0] STEP_M2   = 3'd2;
   localparam logic [2:0] STEP_M3   = 3'd3;
   localparam logic [2:0] STEP_M4   = 3'd4;
   localparam logic [2:0] STEP_X2   = 3'd5;
   localparam logic [2:0] STEP_X3   = 3'd6;
   localparam logic [2:0] STEP_X4   = 3'd7;

   localparam logic [1:0] RSP_NONE = 2'd0;
   localparam logic [1:0] RSP_MOVE = 2'd1;
   localparam logic [1:0] RSP_READ = 2'd2;

   typedef struct packed {
      logic       load_idx;
      logic       rd_next;
      logic       rd_prev;
      logic       rd_b;
      logic [2:0] step;
      logic [1:0] rsp;
   } ilrp_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic a_ok;
      logic b_ok;
      logic slot_free;
   } ilrp_status_type;

endpackage

/* design/ilrp_ram.sv */
// Generic single-write, single-read RAM with registered, read-first read data.
module ilrp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/ilrp_ctrl.sv */
// Controller state machine that sequences the link reads and writes of each item.
module ilrp_ctrl
   import ilrp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [1:0]      req_op,
   input  ilrp_status_type status,
   output logic            req_ready,
   output ilrp_cmd_type    cmd
);

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_M2   = 4'd2;
   localparam logic [3:0] S_M3   = 4'd3;
   localparam logic [3:0] S_M4   = 4'd4;
   localparam logic [3:0] S_X2   = 4'd5;
   localparam logic [3:0] S_X3   = 4'd6;
   localparam logic [3:0] S_X4   = 4'd7;
   localparam logic [3:0] S_R2   = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.step     = STEP_IDLE;
      cmd.rsp      = RSP_NONE;
      case (state_ff)
         S_CLR: begin
            cmd.step = STEP_CLR;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready    = 1'b1;
            cmd.rd_next  = 1'b1;
            cmd.rd_prev  = 1'b1;
            cmd.load_idx = req_valid;
            if (req_valid) begin
               // Unknown codes and out-of-range indexes are taken and dropped.
               case (req_op)
                  OP_MOVE: begin
                     if (status.a_ok && status.b_ok) begin
                        state_in = S_M2;
                     end
                  end
                  OP_CROSS: begin
                     if (status.a_ok && status.b_ok) begin
                        state_in = S_X2;
                     end
                  end
                  OP_READ: begin
                     if (status.a_ok) begin
                        state_in = S_R2;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_M2: begin
            cmd.step    = STEP_M2;
            cmd.rd_next = 1'b1;
            cmd.rd_b    = 1'b1;
            state_in    = S_M3;
         end
         S_M3: begin
            cmd.step = STEP_M3;
            state_in = S_M4;
         end
         S_M4: begin
            // The final writes repeat harmlessly while the result slot is full.
            cmd.step = STEP_M4;
            if (status.slot_free) begin
               cmd.rsp  = RSP_MOVE;
               state_in = S_IDLE;
            end
         end
         S_X2: begin
            cmd.step    = STEP_X2;
            cmd.rd_next = 1'b1;
            cmd.rd_b    = 1'b1;
            state_in    = S_X3;
         end
         S_X3: begin
            cmd.step = STEP_X3;
            state_in = S_X4;
         end
         S_X4: begin
            cmd.step = STEP_X4;
            state_in = S_IDLE;
         end
         S_R2: begin
            if (status.slot_free) begin
               cmd.rsp  = RSP_READ;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLR;
         end
      endcase
   end

endmodule

/* design/ilrp_dpath.sv */
// Datapath with the two link memories, operand registers and the result register.
module ilrp_dpath
   import ilrp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ilrp_cmd_type      cmd,
   input  logic [IDX_W-1:0]  req_index_a,
   input  logic [IDX_W-1:0]  req_index_b,
   input  logic              rsp_ready,
   output ilrp_status_type   status,
   output logic              rsp_valid,
   output logic [7:0]        rsp_next_of,
   output logic [7:0]        rsp_prev_of
);

   localparam logic [LINK_W-1:0] LAST = LINK_W'(ENTRIES - 1);

   logic [LINK_W-1:0] clr_ff;
   logic [LINK_W-1:0] a_ff;
   logic [LINK_W-1:0] b_ff;
   logic [LINK_W-1:0] n_ff;
   logic [LINK_W-1:0] p_ff;
   logic [LINK_W-1:0] t_ff;
   logic              rsp_valid_ff;
   logic [7:0]        rsp_next_ff;
   logic [7:0]        rsp_prev_ff;

   logic [LINK_W-1:0] req_a;
   logic [LINK_W-1:0] req_b;
   logic [LINK_W-1:0] next_rdata;
   logic [LINK_W-1:0] prev_rdata;
   logic [LINK_W-1:0] next_raddr;
   logic [LINK_W-1:0] t_move;
   logic              next_we;
   logic [LINK_W-1:0] next_waddr;
   logic [LINK_W-1:0] next_wdata;
   logic              prev_we;
   logic [LINK_W-1:0] prev_waddr;
   logic [LINK_W-1:0] prev_wdata;

   assign req_a = LINK_W'(req_index_a);
   assign req_b = LINK_W'(req_index_b);

   assign status.a_ok      = 32'(req_index_a) < ENTRIES;
   assign status.b_ok      = 32'(req_index_b) < ENTRIES;
   assign status.clr_last  = clr_ff == LAST;
   assign status.slot_free = !rsp_valid_ff || rsp_ready;

   assign next_raddr = cmd.rd_b ? b_ff : req_a;

   // The read of next(B) in the second move step misses that step's own write
   // and the earlier self-link of A, so both are forwarded here.
   assign t_move = (b_ff == p_ff) ? n_ff :
                   (b_ff == a_ff) ? a_ff : next_rdata;

   always_comb begin
      next_we    = 1'b0;
      next_waddr = '0;
      next_wdata = '0;
      prev_we    = 1'b0;
      prev_waddr = '0;
      prev_wdata = '0;
      case (cmd.step)
         STEP_CLR: begin
            next_we    = 1'b1;
            next_waddr = clr_ff;
            next_wdata = (clr_ff == LAST) ? '0 : clr_ff + 1'b1;
            prev_we    = 1'b1;
            prev_waddr = clr_ff;
            prev_wdata = (clr_ff == '0) ? LAST : clr_ff - 1'b1;
         end
         STEP_M2: begin
            next_we    = 1'b1;
            next_waddr = prev_rdata;
            next_wdata = next_rdata;
            prev_we    = 1'b1;
            prev_waddr = next_rdata;
            prev_wdata = prev_rdata;
         end
         STEP_M3: begin
            next_we    = 1'b1;
            next_waddr = a_ff;
            next_wdata = t_move;
            prev_we    = 1'b1;
            prev_waddr = a_ff;
            prev_wdata = b_ff;
         end
         STEP_M4: begin
            next_we    = 1'b1;
            next_waddr = b_ff;
            next_wdata = a_ff;
            prev_we    = 1'b1;
            prev_waddr = t_ff;
            prev_wdata = a_ff;
         end
         STEP_X3: begin
            next_we    = 1'b1;
            next_waddr = a_ff;
            next_wdata = next_rdata;
            prev_we    = 1'b1;
            prev_waddr = next_rdata;
            prev_wdata = a_ff;
         end
         STEP_X4: begin
            next_we    = 1'b1;
            next_waddr = b_ff;
            next_wdata = n_ff;
            prev_we    = 1'b1;
            prev_waddr = n_ff;
            prev_wdata = b_ff;
         end
         default: begin
            next_we = 1'b0;
         end
      endcase
   end

   ilrp_ram #(.WIDTH(LINK_W), .DEPTH(ENTRIES)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_waddr),
      .wr_data (next_wdata),
      .rd_en   (cmd.rd_next),
      .rd_addr (next_raddr),
      .rd_data (next_rdata)
   );

   ilrp_ram #(.WIDTH(LINK_W), .DEPTH(ENTRIES)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_waddr),
      .wr_data (prev_wdata),
      .rd_en   (cmd.rd_prev),
      .rd_addr (req_a),
      .rd_data (prev_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.step == STEP_CLR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.rsp != RSP_NONE) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_idx) begin
         a_ff <= req_a;
         b_ff <= req_b;
      end
      if (cmd.step == STEP_M2) begin
         n_ff <= next_rdata;
         p_ff <= prev_rdata;
      end
      if (cmd.step == STEP_X2) begin
         n_ff <= next_rdata;
      end
      if (cmd.step == STEP_M3) begin
         t_ff <= t_move;
      end
      case (cmd.rsp)
         RSP_MOVE: begin
            rsp_next_ff <= 8'(n_ff);
            rsp_prev_ff <= 8'd0;
         end
         RSP_READ: begin
            rsp_next_ff <= 8'(next_rdata);
            rsp_prev_ff <= 8'(prev_rdata);
         end
         default: begin
            rsp_next_ff <= rsp_next_ff;
         end
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_next_of = rsp_next_ff;
   assign rsp_prev_of = rsp_prev_ff;

endmodule

/* design/index_linked_ring_pool_core.sv */
// Top level of the linked ring pool: controller plus link memory datapath.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_op, req_index_a, req_index_b
//   rsp      out        rsp_valid/rsp_ready  rsp_next_of, rsp_prev_of
//
// A move steps through M2, M3 and M4 once taken, a cross through X2, X3, X4
// and a read through R2, set by the single write port of each link memory and
// its registered read. After reset a clearing pass writes the initial ring,
// one entry per cycle over all ENTRIES (256) entries, with req_ready low.
// A finished result waits in the output register; a later move or read stalls
// in its last step until that register is free. Dropped items leave it idle.
module index_linked_ring_pool_core
   import ilrp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_op,
   input  logic [IDX_W-1:0] req_index_a,
   input  logic [IDX_W-1:0] req_index_b,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_next_of,
   output logic [7:0]       rsp_prev_of
);

   ilrp_cmd_type    cmd;
   ilrp_status_type status;

   ilrp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   ilrp_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_index_a (req_index_a),
      .req_index_b (req_index_b),
      .rsp_ready   (rsp_ready),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_next_of (rsp_next_of),
      .rsp_prev_of (rsp_prev_of)
   );

endmodule

/* design/ilrp_checker.sv */
// Port-level checker for the ring pool core and its bind to the top level.
`include "index_linked_ring_pool_core_defines.svh"

module ilrp_checker
   import ilrp_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic [1:0]       req_op,
   input logic [IDX_W-1:0] req_index_a,
   input logic [IDX_W-1:0] req_index_b,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [7:0]       rsp_next_of,
   input logic [7:0]       rsp_prev_of
);

   logic req_take;
   logic a_in;
   logic b_in;

   assign req_take = req_valid && req_ready;
   assign a_in     = 32'(req_index_a) < ENTRIES;
   assign b_in     = 32'(req_index_b) < ENTRIES;

   // The clearing pass keeps the block closed right after reset.
   `ILRP_ASSERT_NEXT_ALWAYS(a_reset_closed, clock, reset, !req_ready && !rsp_valid)

   // A result that is not taken stays in place.
   `ILRP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_next_of) && $stable(rsp_prev_of))

   // An in-range move or read keeps the block busy for the next cycle.
   `ILRP_ASSERT_NEXT(a_busy_after_op, clock, reset, req_take && a_in && ((req_op == OP_READ) || (req_op == OP_MOVE && b_in)), !req_ready)

   // A cross never makes a result appear.
   `ILRP_ASSERT_NEXT(a_cross_silent, clock, reset, req_take && req_op == OP_CROSS && !rsp_valid, !rsp_valid)

endmodule

bind index_linked_ring_pool_core ilrp_checker u_ilrp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_op      (req_op),
   .req_index_a (req_index_a),
   .req_index_b (req_index_b),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_next_of (rsp_next_of),
   .rsp_prev_of (rsp_prev_of)
);
